// ===== rtl/core/rpi_pkg.sv =====
// Shared types for the RGB palette indexer.
`default_nettype none

package rpi_pkg;

  typedef struct packed {
    logic [7:0] index;
    logic       added;
    logic       full;
  } scan_res_t;

endpackage

`default_nettype wire

// ===== rtl/core/rgb_palette_indexer.sv =====
// Top level: RGB pixel to global palette index with per-sprite color list.
//
// Input channel: red, green, blue, start_sprite under in_valid / in_stall.
// A transfer happens at a clock edge with in_valid high and in_stall low.
// Output channel: color_index, new_color, palette_full, sprite_full under
// out_valid / out_stall, one result per input transfer, in order.
//
// One pixel is handled at a time. The palette memory is scanned one entry
// per cycle (the read is registered), then the sprite color memory the same
// way. A scan covers only the entries in use, and the sprite list is empty
// after start_sprite; a hit ends a scan early. The next pixel can transfer in
// the cycle after the result is loaded.
//
// Reset (rst, synchronous) empties the palette and the sprite list; no
// memory clearing pass is needed. A stalled result holds in the output
// register; the next pixel may transfer in and be processed meanwhile, and
// its result waits until the output register frees up.
`default_nettype none

module rgb_palette_indexer #(
  parameter int PALETTE_ENTRIES = 256,
  parameter int SPRITE_COLORS   = 16
) (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       in_valid,
  output logic            in_stall,
  input  wire logic [7:0] red,
  input  wire logic [7:0] green,
  input  wire logic [7:0] blue,
  input  wire logic       start_sprite,
  output logic            out_valid,
  input  wire logic       out_stall,
  output logic [7:0]      color_index,
  output logic            new_color,
  output logic            palette_full,
  output logic            sprite_full
);

  typedef enum logic [3:0] {
    T_IDLE = 4'b0001,
    T_PAL  = 4'b0010,
    T_SPR  = 4'b0100,
    T_OUT  = 4'b1000
  } top_state_t;

  top_state_t         state;
  logic               clear_r;
  rpi_pkg::scan_res_t pal_res;
  rpi_pkg::scan_res_t spr_res;
  rpi_pkg::scan_res_t pal_hold;
  logic               pal_done;
  logic               spr_done;
  logic               in_xfer;
  logic               slot_free;
  logic [7:0]         hold_index;
  logic               hold_new;
  logic               hold_pfull;
  logic               hold_sfull;

  assign in_stall  = (state != T_IDLE);
  assign in_xfer   = in_valid && !in_stall;
  assign slot_free = !out_valid || !out_stall;

  rpi_scan #(
    .DEPTH (PALETTE_ENTRIES),
    .WIDTH (24)
  ) u_palette (
    .clk   (clk),
    .rst   (rst),
    .start (in_xfer),
    .clear (1'b0),
    .key   ({red, green, blue}),
    .done  (pal_done),
    .res   (pal_res)
  );

  rpi_scan #(
    .DEPTH (SPRITE_COLORS),
    .WIDTH (8)
  ) u_sprite (
    .clk   (clk),
    .rst   (rst),
    .start (pal_done),
    .clear (clear_r),
    .key   (pal_res.index),
    .done  (spr_done),
    .res   (spr_res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= T_IDLE;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && !out_stall && (state != T_OUT)) begin
        out_valid <= 1'b0;
      end
      case (state)
        T_IDLE: begin
          if (in_xfer) begin
            clear_r <= start_sprite;
            state   <= T_PAL;
          end
        end
        T_PAL: begin
          if (pal_done) begin
            pal_hold <= pal_res;
            state    <= T_SPR;
          end
        end
        T_SPR: begin
          if (spr_done) begin
            hold_index <= spr_res.full ? 8'd0 : pal_hold.index;
            hold_new   <= pal_hold.added;
            hold_pfull <= pal_hold.full;
            hold_sfull <= spr_res.full;
            state      <= T_OUT;
          end
        end
        T_OUT: begin
          if (slot_free) begin
            color_index  <= hold_index;
            new_color    <= hold_new;
            palette_full <= hold_pfull;
            sprite_full  <= hold_sfull;
            out_valid    <= 1'b1;
            state        <= T_IDLE;
          end
        end
        default: begin
          state <= T_IDLE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/rpi_scan.sv =====
// Lookup-or-append table: a memory of keys scanned one entry a cycle.
`default_nettype none

module rpi_scan #(
  parameter int DEPTH = 256,
  parameter int WIDTH = 24
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             start,
  input  wire logic             clear,
  input  wire logic [WIDTH-1:0] key,
  output logic                  done,
  output rpi_pkg::scan_res_t    res
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  typedef enum logic [1:0] {
    SC_IDLE = 2'b01,
    SC_RUN  = 2'b10
  } sc_state_t;

  sc_state_t        state;
  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data;
  logic [AW-1:0]    rd_tag;
  logic             rd_live;
  logic [WIDTH-1:0] key_r;
  logic [CW-1:0]    used;
  logic [CW-1:0]    ptr;

  logic hit;
  logic issue;
  logic miss;
  logic room;
  logic write_en;

  always_comb begin
    hit      = (state == SC_RUN) && rd_live && (rd_data == key_r);
    issue    = (state == SC_RUN) && !hit && (ptr < used);
    miss     = (state == SC_RUN) && !rd_live && (ptr == used);
    room     = used < CW'(DEPTH);
    write_en = miss && room;
  end

  always_ff @(posedge clk) begin
    if (write_en) begin
      mem[used[AW-1:0]] <= key_r;
    end
    if (issue) begin
      rd_data <= mem[ptr[AW-1:0]];
      rd_tag  <= ptr[AW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= SC_IDLE;
      used    <= '0;
      ptr     <= '0;
      rd_live <= 1'b0;
      done    <= 1'b0;
    end else begin
      done    <= hit || miss;
      rd_live <= issue;
      case (state)
        SC_IDLE: begin
          if (start) begin
            key_r <= key;
            ptr   <= '0;
            if (clear) begin
              used <= '0;
            end
            state <= SC_RUN;
          end
        end
        SC_RUN: begin
          if (issue) begin
            ptr <= ptr + CW'(1);
          end
          if (hit) begin
            res.index <= 8'(rd_tag);
            res.added <= 1'b0;
            res.full  <= 1'b0;
            state     <= SC_IDLE;
          end else if (miss) begin
            state <= SC_IDLE;
            if (room) begin
              res.index <= 8'(used[AW-1:0]);
              res.added <= 1'b1;
              res.full  <= 1'b0;
              used      <= used + CW'(1);
            end else begin
              res.index <= '0;
              res.added <= 1'b0;
              res.full  <= 1'b1;
            end
          end
        end
        default: begin
          state <= SC_IDLE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

// ===== tb/rgb_palette_indexer_checker.sv =====
// Checker for the RGB palette indexer: tracks palette and sprite state, predicts each result.
module rgb_palette_indexer_checker #(
  parameter int PALETTE_ENTRIES = 256,
  parameter int SPRITE_COLORS   = 16
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  input  logic       in_stall,
  input  logic [7:0] red,
  input  logic [7:0] green,
  input  logic [7:0] blue,
  input  logic       start_sprite,
  input  logic       out_valid,
  input  logic       out_stall,
  input  logic [7:0] color_index,
  input  logic       new_color,
  input  logic       palette_full,
  input  logic       sprite_full,
  output int         mismatches,
  output int         pending,
  output int         results_seen,
  output int         colors_appended,
  output int         palette_overflows,
  output int         sprite_overflows
);

  typedef struct packed {
    logic [7:0] index;
    logic       added;
    logic       pal_over;
    logic       spr_over;
  } pixel_result_t;

  logic [23:0]   palette [PALETTE_ENTRIES];
  int            palette_count = 0;
  logic [7:0]    sprite_colors [SPRITE_COLORS];
  int            sprite_count = 0;
  pixel_result_t expected_q [$];
  pixel_result_t want;
  int            n_errors = 0;
  int            n_results = 0;
  int            n_added = 0;
  int            n_pal_over = 0;
  int            n_spr_over = 0;

  function automatic pixel_result_t index_pixel(input logic [23:0] rgb, input logic start);
    pixel_result_t r;
    logic          hit;
    int            k;
    r   = '0;
    hit = 1'b0;
    for (k = 0; k < palette_count; k++) begin
      if (!hit && palette[k] == rgb) begin
        r.index = k[7:0];
        hit     = 1'b1;
      end
    end
    if (!hit) begin
      if (palette_count < PALETTE_ENTRIES) begin
        r.index                = palette_count[7:0];
        palette[palette_count] = rgb;
        palette_count++;
        r.added = 1'b1;
        n_added++;
      end else begin
        r.index    = 8'd0;
        r.pal_over = 1'b1;
        n_pal_over++;
      end
    end
    if (start) sprite_count = 0;
    hit = 1'b0;
    for (k = 0; k < sprite_count; k++) begin
      if (sprite_colors[k] == r.index) hit = 1'b1;
    end
    if (!hit) begin
      if (sprite_count < SPRITE_COLORS) begin
        sprite_colors[sprite_count] = r.index;
        sprite_count++;
      end else begin
        r.index    = 8'd0;
        r.spr_over = 1'b1;
        n_spr_over++;
      end
    end
    return r;
  endfunction

  task automatic report(input string what, input int got, input int exp_val);
    $display("result %0d: %s got %0d, expected %0d", n_results, what, got, exp_val);
    n_errors++;
  endtask

  always @(posedge clk) begin
    if (!rst && in_valid && !in_stall) begin
      expected_q.push_back(index_pixel({red, green, blue}, start_sprite));
    end
    if (!rst && out_valid && !out_stall) begin
      n_results++;
      if (expected_q.size() == 0) begin
        report("no pixel pending, color_index", int'(color_index), -1);
      end else begin
        want = expected_q.pop_front();
        if (color_index !== want.index)
          report("color_index", int'(color_index), int'(want.index));
        if (new_color !== want.added)
          report("new_color", int'(new_color), int'(want.added));
        if (palette_full !== want.pal_over)
          report("palette_full", int'(palette_full), int'(want.pal_over));
        if (sprite_full !== want.spr_over)
          report("sprite_full", int'(sprite_full), int'(want.spr_over));
      end
    end
    mismatches        <= n_errors;
    pending           <= expected_q.size();
    results_seen      <= n_results;
    colors_appended   <= n_added;
    palette_overflows <= n_pal_over;
    sprite_overflows  <= n_spr_over;
  end

endmodule

// ===== tb/rgb_palette_indexer_test.sv =====
// Testbench top for the RGB palette indexer: clock, reset, pixel stimulus and verdict.
module rgb_palette_indexer_test;

  localparam int PALETTE_ENTRIES = 256;
  localparam int SPRITE_COLORS   = 16;
  localparam int PIXEL_TOTAL     = 1650;
  localparam int HOLD_AT         = 400;
  localparam int HOLD_CYCLES     = 1500;
  localparam int DRAIN_CYCLES    = 400;
  localparam int CYCLE_LIMIT     = 3000000;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       in_valid = 1'b0;
  logic       in_stall;
  logic [7:0] red = 8'd0;
  logic [7:0] green = 8'd0;
  logic [7:0] blue = 8'd0;
  logic       start_sprite = 1'b0;
  logic       out_valid;
  logic       out_stall = 1'b0;
  logic [7:0] color_index;
  logic       new_color;
  logic       palette_full;
  logic       sprite_full;

  int mismatches;
  int pending;
  int results_seen;
  int colors_appended;
  int palette_overflows;
  int sprite_overflows;

  int          n_sent = 0;
  int          sent_mark = 0;
  int          burst_left = 0;
  int          cycle_count = 0;
  logic [23:0] seen_colors [$];

  always #1 clk = ~clk;

  rgb_palette_indexer #(
    .PALETTE_ENTRIES(PALETTE_ENTRIES),
    .SPRITE_COLORS  (SPRITE_COLORS)
  ) DUT (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .red         (red),
    .green       (green),
    .blue        (blue),
    .start_sprite(start_sprite),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .color_index (color_index),
    .new_color   (new_color),
    .palette_full(palette_full),
    .sprite_full (sprite_full)
  );

  rgb_palette_indexer_checker #(
    .PALETTE_ENTRIES(PALETTE_ENTRIES),
    .SPRITE_COLORS  (SPRITE_COLORS)
  ) checker_i (
    .clk              (clk),
    .rst              (rst),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .red              (red),
    .green            (green),
    .blue             (blue),
    .start_sprite     (start_sprite),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .color_index      (color_index),
    .new_color        (new_color),
    .palette_full     (palette_full),
    .sprite_full      (sprite_full),
    .mismatches       (mismatches),
    .pending          (pending),
    .results_seen     (results_seen),
    .colors_appended  (colors_appended),
    .palette_overflows(palette_overflows),
    .sprite_overflows (sprite_overflows)
  );

  task automatic offer_pixel(input logic [23:0] rgb, input logic start);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 40);
      gap = ($urandom_range(0, 15) == 0) ? $urandom_range(20, 300) : $urandom_range(1, 8);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    burst_left--;
    in_valid           <= 1'b1;
    {red, green, blue} <= rgb;
    start_sprite       <= start;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    n_sent++;
    sent_mark <= n_sent;
  endtask

  // receiver: stall stretches of varying density, plus one long hold-off
  initial begin
    int  span;
    int  mode;
    bit  held;
    held = 1'b0;
    forever begin
      if (!held && sent_mark >= HOLD_AT) begin
        held = 1'b1;
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else begin
        span = $urandom_range(20, 300);
        mode = $urandom_range(0, 2);
        repeat (span) begin
          if (mode == 0) out_stall <= 1'b0;
          else if (mode == 1) out_stall <= ($urandom_range(0, 3) == 0);
          else out_stall <= ($urandom_range(0, 3) != 0);
          @(posedge clk);
        end
      end
    end
  end

  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("TB_ERROR");
    $finish;
  end

  initial begin
    logic [23:0] rgb;
    logic [23:0] sprite_set [$];
    int          k;
    int          len;
    int          set_size;
    int          new_pct;

    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // fill a sprite list, overflow it, then restart the sprite
    offer_pixel(24'h000000, 1'b1);
    offer_pixel(24'hFFFFFF, 1'b0);
    offer_pixel(24'h000000, 1'b0);
    for (k = 1; k <= 14; k++) offer_pixel(24'(24'h010101 * k), 1'b0);
    offer_pixel(24'h0F0F0F, 1'b0);
    offer_pixel(24'h0F0F0F, 1'b0);
    offer_pixel(24'hFFFFFF, 1'b0);
    offer_pixel(24'h0F0F0F, 1'b1);
    offer_pixel(24'h7FFFFF, 1'b0);
    offer_pixel(24'h800000, 1'b0);
    seen_colors = '{24'h000000, 24'hFFFFFF, 24'h0F0F0F, 24'h7FFFFF, 24'h800000};

    while (n_sent < PIXEL_TOTAL) begin
      if ($urandom_range(0, 9) == 0) begin
        len = $urandom_range(1, 10);
        repeat (len) begin
          if ($urandom_range(0, 1) == 1)
            rgb = seen_colors[$urandom_range(0, seen_colors.size() - 1)];
          else rgb = 24'($urandom());
          offer_pixel(rgb, 1'($urandom_range(0, 1)));
        end
      end else begin
        set_size = $urandom_range(1, 24);
        new_pct  = (seen_colors.size() < PALETTE_ENTRIES) ? 70 : 20;
        sprite_set.delete();
        repeat (set_size) begin
          if ($urandom_range(0, 99) < new_pct) begin
            rgb = 24'($urandom());
            seen_colors.push_back(rgb);
          end else begin
            rgb = seen_colors[$urandom_range(0, seen_colors.size() - 1)];
          end
          sprite_set.push_back(rgb);
        end
        len = $urandom_range(1, 40);
        for (k = 0; k < len; k++) offer_pixel(sprite_set[$urandom_range(0, set_size - 1)], k == 0);
      end
    end

    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("pixels %0d, results %0d: %0d colors appended, %0d palette overflows",
             n_sent, results_seen, colors_appended, palette_overflows);
    $display("%0d sprite overflows; sprite restarts, bursty input and a long output hold-off",
             sprite_overflows);
    if (mismatches == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
